>>> rtl/core/tpi_pkg.sv
// ----------------------------------------------------------------------------
// Trapezoid polynomial integrator package
// Shared widths, request codes, sequencer types and the Horner step helper.
// ----------------------------------------------------------------------------
package tpi_pkg;

  // Default number of coefficient table entries.
  localparam int unsigned COEF_DEPTH_DEF = 16;

  // Field widths.
  localparam int unsigned DATA_W = 32;
  localparam int unsigned DEG_W  = 4;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned STEP_W = 16;
  localparam int unsigned AREA_W = 47;

  // Twice the trapezoid sum is held exactly in this many bits.
  localparam int unsigned SUM_W  = 51;

  // Shared multiplier operand and product widths.
  localparam int unsigned MUL_W  = 33;
  localparam int unsigned PROD_W = 2 * MUL_W;

  // Horner step intermediate: floor(product / 2^16) plus a coefficient.
  localparam int unsigned HSUM_W = 49;

  // Largest representable area.
  localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

  // Request codes.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_RUN  = 1'b1;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_PT_START,
    ST_PT_INIT,
    ST_PT_MUL,
    ST_PT_ADD,
    ST_PT_ACC,
    ST_FIN_ABS,
    ST_FIN_HI,
    ST_FIN_LO,
    ST_FIN_OUT
  } state_e;

  // Which sample point is being evaluated.
  typedef enum logic [1:0] {
    PT_LOWER,
    PT_UPPER,
    PT_INNER
  } point_e;

  // Result of one Horner multiply-add.
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              sat;
  } horner_t;

  // acc = sat32(floor(prod / 2^16) + coef). The product of two 32-bit signed
  // values fits 64 bits, so bits 63:16 are the floored quotient.
  function automatic horner_t horner_step(input logic [PROD_W-1:0] prod,
                                          input logic [DATA_W-1:0] coef);
    logic signed [HSUM_W-1:0] sum;
    horner_t                  res;
    sum = signed'({prod[63], prod[63:16]}) +
          signed'({{(HSUM_W-DATA_W){coef[DATA_W-1]}}, coef});
    if ((&sum[HSUM_W-1:DATA_W-1]) || !(|sum[HSUM_W-1:DATA_W-1])) begin
      res.value = sum[DATA_W-1:0];
      res.sat   = 1'b0;
    end else if (sum[HSUM_W-1]) begin
      res.value = {1'b1, {(DATA_W-1){1'b0}}};
      res.sat   = 1'b1;
    end else begin
      res.value = {1'b0, {(DATA_W-1){1'b1}}};
      res.sat   = 1'b1;
    end
    return res;
  endfunction

endpackage

>>> rtl/core/trapezoid_poly_integrator.sv
// ----------------------------------------------------------------------------
// Trapezoid polynomial integrator
// A load transaction is taken whenever the block is idle. A run evaluates the
// polynomial at n+1 sample points, the shared multiplier doing each Horner step;
// the block takes no new transaction until a run finishes.
// Reset: degree 0, coefficient table reads zero, no result pending.
// ----------------------------------------------------------------------------
module trapezoid_poly_integrator #(
  parameter int COEF_DEPTH = tpi_pkg::COEF_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration
  input  logic                               cfg_we_i,
  input  logic [tpi_pkg::DEG_W-1:0]          cfg_wdata_i,
  // Input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               req_type_i,
  input  logic [tpi_pkg::IDX_W-1:0]          coef_index_i,
  input  logic signed [tpi_pkg::DATA_W-1:0]  coef_value_i,
  input  logic signed [tpi_pkg::DATA_W-1:0]  lower_bound_i,
  input  logic signed [tpi_pkg::DATA_W-1:0]  upper_bound_i,
  input  logic [tpi_pkg::STEP_W-1:0]         step_count_i,
  // Output channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [tpi_pkg::AREA_W-1:0]         area_o,
  output logic                               overflow_o
);

  localparam int AW     = $clog2(COEF_DEPTH);
  localparam int DW     = (AW > 4) ? AW : 4;
  localparam int CW     = (AW + 1 > 4) ? AW + 1 : 4;
  localparam int DATA_W = tpi_pkg::DATA_W;
  localparam int SUM_W  = tpi_pkg::SUM_W;
  localparam int MUL_W  = tpi_pkg::MUL_W;
  localparam int AREA_W = tpi_pkg::AREA_W;
  localparam int STEP_W = tpi_pkg::STEP_W;
  localparam int HI_W   = SUM_W - DATA_W;
  localparam int HSH_W  = AREA_W - DATA_W;
  localparam int LSH    = DATA_W - HSH_W;

  tpi_pkg::state_e state_q, state_d;
  tpi_pkg::point_e kind_q, kind_d;

  logic [tpi_pkg::DEG_W-1:0]  degree_q;
  logic [DATA_W-1:0]          a_q, a_d;
  logic [DATA_W-1:0]          b_q, b_d;
  logic [STEP_W-1:0]          n_q, n_d;
  logic [STEP_W-1:0]          rem_q, rem_d;
  logic [AW-1:0]              deg_q, deg_d;
  logic [AW-1:0]              k_q, k_d;
  logic [DATA_W-1:0]          x_q, x_d;
  logic [DATA_W:0]            h_q, h_d;
  logic [DATA_W-1:0]          hmag_q, hmag_d;
  logic [DATA_W-1:0]          acc_q, acc_d;
  logic [SUM_W-1:0]           s2_q, s2_d;
  logic [SUM_W-1:0]           mag_q, mag_d;
  logic [DATA_W-1:0]          hih_q, hih_d;
  logic                       hi_ovf_q, hi_ovf_d;
  logic                       neg_q, neg_d;
  logic                       ovf_q, ovf_d;
  logic                       out_valid_q, out_valid_d;
  logic [AREA_W-1:0]          area_q, area_d;
  logic                       out_ovf_q, out_ovf_d;

  logic                       in_accept;
  logic [DW-1:0]              deg_ext;
  logic [AW-1:0]              deg_eff;
  logic                       idx_ok;
  logic                       mem_we;
  logic [AW-1:0]              mem_raddr;
  logic [DATA_W-1:0]          mem_rdata;
  logic                       div_start;
  logic                       div_busy;
  logic [DATA_W-1:0]          div_quo;
  logic [DATA_W-1:0]          diff_mag;
  logic signed [MUL_W-1:0]    mul_a, mul_b;
  logic [tpi_pkg::PROD_W-1:0] prod;
  tpi_pkg::horner_t           hstep;
  logic [SUM_W-1:0]           f_ext;
  logic signed [DATA_W+1:0]   x_next;
  logic [AREA_W:0]            area_sum;

  assign in_accept = in_valid_i && !in_stall_o;

  // Degree clamped to the table size.
  assign deg_ext = DW'(degree_q);
  assign deg_eff = (deg_ext > DW'(COEF_DEPTH - 1)) ? AW'(COEF_DEPTH - 1) : deg_ext[AW-1:0];

  // Coefficient loads beyond the table are dropped.
  assign idx_ok = CW'(coef_index_i) < CW'(COEF_DEPTH);
  assign mem_we = in_accept && (req_type_i == tpi_pkg::REQ_LOAD) && idx_ok;

  // |b - a| fits 32 bits unsigned.
  assign diff_mag = neg_q ? DATA_W'(a_q - b_q) : DATA_W'(b_q - a_q);

  // Horner step from the registered product and the prefetched coefficient.
  assign hstep = tpi_pkg::horner_step(prod, mem_rdata);

  // Sample value widened for the running sum.
  assign f_ext = SUM_W'(signed'(acc_q));

  // Next sample point: from a for the first inner point, else from x.
  assign x_next = (kind_q == tpi_pkg::PT_UPPER)
                ? (DATA_W+2)'(signed'(a_q)) + (DATA_W+2)'(signed'(h_q))
                : (DATA_W+2)'(signed'(x_q)) + (DATA_W+2)'(signed'(h_q));

  // Final area: (hi*h << 15) + (lo*h >> 17).
  assign area_sum = (AREA_W+1)'({hih_q, {HSH_W{1'b0}}}) + (AREA_W+1)'(prod[63:LSH]);

  // Shared multiplier operand selection. The low half product is held while
  // the final step waits for the output register.
  always_comb begin
    unique case (state_q)
      tpi_pkg::ST_FIN_HI: begin
        mul_a = signed'({{(MUL_W-HI_W){1'b0}}, mag_q[SUM_W-1:DATA_W]});
        mul_b = signed'({1'b0, hmag_q});
      end
      tpi_pkg::ST_FIN_LO, tpi_pkg::ST_FIN_OUT: begin
        mul_a = signed'({1'b0, mag_q[DATA_W-1:0]});
        mul_b = signed'({1'b0, hmag_q});
      end
      default: begin
        mul_a = signed'({acc_q[DATA_W-1], acc_q});
        mul_b = signed'({x_q[DATA_W-1], x_q});
      end
    endcase
  end

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    a_d         = a_q;
    b_d         = b_q;
    n_d         = n_q;
    rem_d       = rem_q;
    deg_d       = deg_q;
    k_d         = k_q;
    x_d         = x_q;
    h_d         = h_q;
    hmag_d      = hmag_q;
    acc_d       = acc_q;
    s2_d        = s2_q;
    mag_d       = mag_q;
    hih_d       = hih_q;
    hi_ovf_d    = hi_ovf_q;
    neg_d       = neg_q;
    ovf_d       = ovf_q;
    area_d      = area_q;
    out_ovf_d   = out_ovf_q;
    out_valid_d = out_valid_q && out_stall_i;
    div_start   = 1'b0;
    mem_raddr   = k_q;
    in_stall_o  = state_q != tpi_pkg::ST_IDLE;

    unique case (state_q)
      tpi_pkg::ST_IDLE: begin
        if (in_valid_i && (req_type_i == tpi_pkg::REQ_RUN)) begin
          a_d     = lower_bound_i;
          b_d     = upper_bound_i;
          n_d     = (step_count_i == '0) ? STEP_W'(1) : step_count_i;
          rem_d   = (step_count_i == '0) ? '0 : step_count_i - 1'b1;
          neg_d   = upper_bound_i < lower_bound_i;
          deg_d   = deg_eff;
          state_d = tpi_pkg::ST_DIV_START;
        end
      end
      tpi_pkg::ST_DIV_START: begin
        div_start = 1'b1;
        state_d   = tpi_pkg::ST_DIV_WAIT;
      end
      tpi_pkg::ST_DIV_WAIT: begin
        if (!div_busy) begin
          hmag_d  = div_quo;
          h_d     = neg_q ? (DATA_W+1)'(-{1'b0, div_quo}) : {1'b0, div_quo};
          x_d     = a_q;
          kind_d  = tpi_pkg::PT_LOWER;
          s2_d    = '0;
          ovf_d   = 1'b0;
          state_d = tpi_pkg::ST_PT_START;
        end
      end
      tpi_pkg::ST_PT_START: begin
        // Fetch the leading coefficient.
        mem_raddr = deg_q;
        state_d   = tpi_pkg::ST_PT_INIT;
      end
      tpi_pkg::ST_PT_INIT: begin
        acc_d   = mem_rdata;
        k_d     = deg_q;
        state_d = (deg_q == '0) ? tpi_pkg::ST_PT_ACC : tpi_pkg::ST_PT_MUL;
      end
      tpi_pkg::ST_PT_MUL: begin
        // Multiply while the next coefficient is read.
        mem_raddr = k_q - 1'b1;
        k_d       = k_q - 1'b1;
        state_d   = tpi_pkg::ST_PT_ADD;
      end
      tpi_pkg::ST_PT_ADD: begin
        acc_d   = hstep.value;
        ovf_d   = ovf_q | hstep.sat;
        state_d = (k_q == '0) ? tpi_pkg::ST_PT_ACC : tpi_pkg::ST_PT_MUL;
      end
      tpi_pkg::ST_PT_ACC: begin
        // End points count once, inner points twice.
        s2_d = (kind_q == tpi_pkg::PT_INNER) ? s2_q + {f_ext[SUM_W-2:0], 1'b0}
                                             : s2_q + f_ext;
        unique case (kind_q)
          tpi_pkg::PT_LOWER: begin
            x_d     = b_q;
            kind_d  = tpi_pkg::PT_UPPER;
            state_d = tpi_pkg::ST_PT_START;
          end
          tpi_pkg::PT_UPPER: begin
            if (rem_q == '0) begin
              state_d = tpi_pkg::ST_FIN_ABS;
            end else begin
              x_d     = x_next[DATA_W-1:0];
              kind_d  = tpi_pkg::PT_INNER;
              state_d = tpi_pkg::ST_PT_START;
            end
          end
          default: begin
            if (rem_q == STEP_W'(1)) begin
              state_d = tpi_pkg::ST_FIN_ABS;
            end else begin
              rem_d   = rem_q - 1'b1;
              x_d     = x_next[DATA_W-1:0];
              state_d = tpi_pkg::ST_PT_START;
            end
          end
        endcase
      end
      tpi_pkg::ST_FIN_ABS: begin
        mag_d   = s2_q[SUM_W-1] ? -s2_q : s2_q;
        state_d = tpi_pkg::ST_FIN_HI;
      end
      tpi_pkg::ST_FIN_HI: begin
        state_d = tpi_pkg::ST_FIN_LO;
      end
      tpi_pkg::ST_FIN_LO: begin
        hih_d    = prod[DATA_W-1:0];
        hi_ovf_d = |prod[tpi_pkg::PROD_W-1:DATA_W];
        state_d  = tpi_pkg::ST_FIN_OUT;
      end
      tpi_pkg::ST_FIN_OUT: begin
        // Wait for the output register to be free.
        if (!out_valid_q || !out_stall_i) begin
          if (hi_ovf_q || area_sum[AREA_W]) begin
            area_d    = tpi_pkg::AREA_MAX;
            out_ovf_d = 1'b1;
          end else begin
            area_d    = area_sum[AREA_W-1:0];
            out_ovf_d = ovf_q;
          end
          out_valid_d = 1'b1;
          state_d     = tpi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tpi_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tpi_pkg::ST_IDLE;
      kind_q      <= tpi_pkg::PT_LOWER;
      degree_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        degree_q <= cfg_wdata_i;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    a_q       <= a_d;
    b_q       <= b_d;
    n_q       <= n_d;
    rem_q     <= rem_d;
    deg_q     <= deg_d;
    k_q       <= k_d;
    x_q       <= x_d;
    h_q       <= h_d;
    hmag_q    <= hmag_d;
    acc_q     <= acc_d;
    s2_q      <= s2_d;
    mag_q     <= mag_d;
    hih_q     <= hih_d;
    hi_ovf_q  <= hi_ovf_d;
    neg_q     <= neg_d;
    ovf_q     <= ovf_d;
    area_q    <= area_d;
    out_ovf_q <= out_ovf_d;
  end

  tpi_coef_mem #(
    .DEPTH(COEF_DEPTH)
  ) u_coef_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (mem_we),
    .waddr_i(AW'(coef_index_i)),
    .wdata_i(coef_value_i),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  tpi_divider #(
    .NUM_W(DATA_W),
    .DEN_W(STEP_W)
  ) u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (diff_mag),
    .den_i  (n_q),
    .busy_o (div_busy),
    .quo_o  (div_quo)
  );

  tpi_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .prod_o(prod)
  );

  assign out_valid_o = out_valid_q;
  assign area_o      = area_q;
  assign overflow_o  = out_ovf_q;

  // An accepted run makes the block busy on the next cycle.
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (req_type_i == tpi_pkg::REQ_RUN) |=> in_stall_o)
    else $error("run transaction did not start the sequencer");

  // A new result appears only from the final sequencer step.
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == tpi_pkg::ST_FIN_OUT)
    else $error("result raised outside the final step");

  // The divider is idle during the Horner multiply and add steps.
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tpi_pkg::ST_PT_MUL || state_q == tpi_pkg::ST_PT_ADD) |-> !div_busy)
    else $error("divider busy during evaluation");

  // The Horner index never exceeds the captured degree.
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tpi_pkg::ST_PT_ADD) |-> (k_q < deg_q))
    else $error("Horner index out of range");

endmodule

>>> rtl/core/tpi_coef_mem.sv
// ----------------------------------------------------------------------------
// Coefficient table
// One write port and one registered read port; entries never written read
// as zero through per-entry valid bits cleared by reset.
// ----------------------------------------------------------------------------
module tpi_coef_mem #(
  parameter int DEPTH = tpi_pkg::COEF_DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [tpi_pkg::DATA_W-1:0] wdata_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [tpi_pkg::DATA_W-1:0] rdata_o
);

  logic [tpi_pkg::DATA_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]           valid_q;
  logic [tpi_pkg::DATA_W-1:0] rdata_q;

  // Storage array write.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Valid bits mark entries written since reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  // Registered read; an unwritten entry reads as zero through its valid bit.
  always_ff @(posedge clk_i) begin
    rdata_q <= valid_q[raddr_i] ? mem_q[raddr_i] : '0;
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/tpi_divider.sv
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned division, one quotient bit per cycle, for the step width.
// ----------------------------------------------------------------------------
module tpi_divider #(
  parameter int NUM_W = tpi_pkg::DATA_W,
  parameter int DEN_W = tpi_pkg::STEP_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  // Shift in the next dividend bit and try to subtract the divisor.
  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  // Iteration counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_W'(NUM_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[NUM_W-2:0], fits};
      rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign busy_o = cnt_q != '0;
  assign quo_o  = quo_q;

endmodule

>>> rtl/core/tpi_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed multiply with a registered product, used for Horner steps and for
// the final area product.
// ----------------------------------------------------------------------------
module tpi_mul (
  input  logic                               clk_i,
  input  logic signed [tpi_pkg::MUL_W-1:0]   a_i,
  input  logic signed [tpi_pkg::MUL_W-1:0]   b_i,
  output logic        [tpi_pkg::PROD_W-1:0]  prod_o
);

  logic signed [tpi_pkg::PROD_W-1:0] prod_q;

  // One multiplication per cycle, product registered.
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule
